### src/indexed_double_ended_queue_macros.svh
// ----------------------------------------------------------------------------
// indexed double-ended queue assertion macros
// shared helpers for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define INDEXED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// property that must hold at every clock edge outside reset
`define IDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition that must never be seen outside reset
`define IDQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### src/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// types and constants of the indexed double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package idq_pkg;

  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;

  typedef enum logic [2:0] {
    REQ_READ      = 3'd0,
    REQ_WRITE     = 3'd1,
    REQ_PUSH_TAIL = 3'd2,
    REQ_PUSH_HEAD = 3'd3,
    REQ_POP_TAIL  = 3'd4,
    REQ_POP_HEAD  = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]               req_type;
    logic [5:0]               index;
    logic signed [WORD_W-1:0] value;
  } idq_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [6:0]               item_count;
    logic [1:0]               status;
  } idq_rsp_t;

endpackage

`default_nettype wire

### src/idq_ram.sv
// ----------------------------------------------------------------------------
// idq_ram
// single-port word store of the queue ring, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module idq_ram (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic                       we_i,
  input  wire logic [idq_pkg::PTR_W-1:0]  addr_i,
  input  wire logic [idq_pkg::WORD_W-1:0] wdata_i,
  output logic      [idq_pkg::WORD_W-1:0] rdata_o
);
  import idq_pkg::*;

  logic [WORD_W-1:0] mem_q [CAPACITY];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/indexed_double_ended_queue.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_queue
// ring-buffer deque of 32-bit words with indexed read and write
// ----------------------------------------------------------------------------
// usage:
//   a request (read or write at a logical index, push or pop at either end)
//   is taken on req_i at a rising edge where start_i is high and busy_o low.
//   exactly one response follows on rsp_o in the next cycle, marked by
//   done_o for that one cycle; it carries the read word (zero unless an ok
//   read), the item count after the request and a status code.
//   a new request may be started every cycle while busy_o is low:
//   each request makes a single access to the word store, a single-port ram
//   with registered read data, and the head pointer and count update at the
//   accept edge. a write lands in the ram at its accept edge, so a read
//   started right after it already sees the new word.
//   the receiver cannot stall; done_o is a one-cycle strobe and the response
//   is lost if not taken.
//   reset clears the head pointer and the count; the ram is not cleared,
//   since only words inside the live window are ever read. busy_o is high
//   during reset and for the first cycle after it.
//   flagged requests (full, empty, index out of range) change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_double_ended_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire idq_pkg::idq_req_t req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output idq_pkg::idq_rsp_t      rsp_o
);
  import idq_pkg::*;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;
  logic              rd_sel_q, rd_sel_d;
  logic              done_q;
  logic              busy_q;

  logic              accept;
  logic              mem_en;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_addr;
  logic [WORD_W-1:0] mem_rdata;
  logic [PTR_W-1:0]  head_dec;
  logic [PTR_W-1:0]  head_inc;
  logic              full;
  logic              empty;
  logic              in_range;

  // physical slot of a logical offset, sum stays below twice the capacity
  function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return PTR_W'(sum);
  endfunction

  assign accept   = start_i && !busy_q;
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign in_range = (32'(req_i.index) < 32'(count_q));
  assign head_dec = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - 1'b1;
  assign head_inc = (head_q == PTR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = ST_OK;
    rd_sel_d = 1'b0;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = ring_pos(head_q, CNT_W'(req_i.index));
    if (accept) begin
      unique case (req_i.req_type)
        REQ_READ: begin
          if (in_range) begin
            mem_en   = 1'b1;
            rd_sel_d = 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        REQ_WRITE: begin
          if (in_range) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        REQ_PUSH_TAIL: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = ring_pos(head_q, count_q);
            count_d  = count_q + 1'b1;
          end
        end
        REQ_PUSH_HEAD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = head_dec;
            head_d   = head_dec;
            count_d  = count_q + 1'b1;
          end
        end
        REQ_POP_TAIL: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        REQ_POP_HEAD: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            head_d  = head_inc;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
      rd_sel_q <= 1'b0;
      done_q   <= 1'b0;
      busy_q   <= 1'b1;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
      done_q   <= accept;
      busy_q   <= 1'b0;
    end
  end

  idq_ram u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (req_i.value),
    .rdata_o (mem_rdata)
  );

  // count register already holds the value after the answered request
  assign busy_o            = busy_q;
  assign done_o            = done_q;
  assign rsp_o.read_value  = rd_sel_q ? mem_rdata : '0;
  assign rsp_o.item_count  = 7'(count_q);
  assign rsp_o.status      = status_q;

  `include "indexed_double_ended_queue_macros.svh"

  `IDQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "item count above capacity")
  `IDQ_ASSERT(a_one_response, accept |=> done_o, "request without response")
  `IDQ_ASSERT(a_no_stray_response, !accept |=> !done_o, "response without request")
  `IDQ_ASSERT(a_push_grows,
    accept && !full && (req_i.req_type == REQ_PUSH_TAIL || req_i.req_type == REQ_PUSH_HEAD)
    |=> count_q == $past(count_q) + 1'b1, "push did not grow the count")
  `IDQ_ASSERT_NEVER(a_read_zero, done_o && !rd_sel_q && rsp_o.read_value != '0,
    "read word on a response that is not an ok read")

endmodule

`default_nettype wire
